// ----- hw/rtl/esc_lz_pkg.sv -----
`timescale 1ns / 1ps

package esc_lz_pkg;

    // history window, a power of two
    localparam int unsigned HIST_DEPTH = 65536;
    localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);

    localparam logic [31:0] HEADER_BYTES   = 32'd9;
    localparam logic [13:0] MIN_MATCH      = 14'd4;
    localparam logic [1:0]  DIST_SIZE_MASK = 2'h3;
    localparam int unsigned LEN_EXT_BIT    = 2;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_DIST_SIZE  = 2'd1,
        ERR_DIST_FAR   = 2'd2,
        ERR_UNEXPECTED = 2'd3
    } t_err;

    // one accepted item as the parser hands it to the output stage
    typedef struct packed {
        logic               has_result;
        logic               wr_en;
        logic               is_copy;
        logic [7:0]         lit_byte;
        logic               last;
        t_err               err;
        logic [HIST_AW-1:0] wr_addr;
        logic [HIST_AW-1:0] rd_addr;
    } t_item;

endpackage

// ----- hw/rtl/esc_lz_ram.sv -----
`timescale 1ns / 1ps

module esc_lz_ram #(
    parameter int unsigned ADDR_W = 16,
    parameter int unsigned DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/esc_lz_parse.sv -----
`timescale 1ns / 1ps

module esc_lz_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic                i_op,
    input  logic [7:0]          i_in_byte,
    output esc_lz_pkg::t_item   o_item
);

    typedef enum logic [2:0] {
        PH_HDR_ORIG,
        PH_HDR_COMP,
        PH_HDR_ESC,
        PH_IDLE,
        PH_ESC,
        PH_LEN_EXT,
        PH_DIST,
        PH_COPY
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_cnt, n_cnt;
    logic [31:0] r_orig, n_orig;
    logic [31:0] r_cleft, n_cleft;
    logic [7:0]  r_esc, n_esc;
    logic [1:0]  r_dsize, n_dsize;
    logic [13:0] r_len, n_len;
    logic [24:0] r_dist, n_dist;
    logic [31:0] r_prod, n_prod;

    logic [31:0] prod_inc;
    logic [31:0] cl_dec;
    logic [31:0] cl_hdr;
    logic [7:0]  code;
    logic [24:0] dist_acc;
    logic [24:0] dist_fin;
    esc_lz_pkg::t_item item;

    assign prod_inc = r_prod + 32'd1;
    assign cl_dec   = (r_cleft != 32'd0) ? r_cleft - 32'd1 : r_cleft;
    assign cl_hdr   = (r_cleft >= esc_lz_pkg::HEADER_BYTES) ?
                      r_cleft - esc_lz_pkg::HEADER_BYTES : 32'd0;
    assign code     = (i_in_byte > r_esc) ? i_in_byte - 8'd1 : i_in_byte;

    always_comb begin
        dist_acc = r_dist;
        case (r_cnt)
            2'd0:    dist_acc[7:0]   = i_in_byte;
            2'd1:    dist_acc[15:8]  = i_in_byte;
            2'd2:    dist_acc[23:16] = i_in_byte;
            default: dist_acc        = r_dist;
        endcase
    end

    assign dist_fin = dist_acc + 25'd1;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_orig  = r_orig;
        n_cleft = r_cleft;
        n_esc   = r_esc;
        n_dsize = r_dsize;
        n_len   = r_len;
        n_dist  = r_dist;
        n_prod  = r_prod;

        item            = '0;
        item.err        = esc_lz_pkg::ERR_NONE;
        item.lit_byte   = i_in_byte;
        item.last       = (prod_inc == r_orig);
        item.wr_addr    = r_prod[esc_lz_pkg::HIST_AW-1:0];
        item.rd_addr    = r_prod[esc_lz_pkg::HIST_AW-1:0] -
                          r_dist[esc_lz_pkg::HIST_AW-1:0];

        if (i_acc) begin
            if (i_op) begin
                if (r_phase != PH_COPY) begin
                    item.has_result = 1'b1;
                    item.err        = esc_lz_pkg::ERR_UNEXPECTED;
                    item.lit_byte   = 8'd0;
                    item.last       = 1'b0;
                end else begin
                    item.has_result = 1'b1;
                    item.wr_en      = 1'b1;
                    item.is_copy    = 1'b1;
                    n_prod          = prod_inc;
                    n_len           = r_len - 14'd1;
                    if (r_len == 14'd1) begin
                        n_phase = (r_cleft == 32'd0) ? PH_HDR_ORIG : PH_IDLE;
                        n_cnt   = 2'd0;
                    end
                end
            end else if (r_phase == PH_COPY) begin
                item.has_result = 1'b1;
                item.err        = esc_lz_pkg::ERR_UNEXPECTED;
                item.lit_byte   = 8'd0;
                item.last       = 1'b0;
            end else begin
                case (r_phase)
                    PH_HDR_ORIG: begin
                        if (r_cnt == 2'd0) begin
                            n_orig = 32'd0;
                        end
                        n_orig[{r_cnt, 3'b000} +: 8] = i_in_byte;
                        n_cnt = r_cnt + 2'd1;
                        if (r_cnt == 2'd3) begin
                            n_phase = PH_HDR_COMP;
                        end
                    end
                    PH_HDR_COMP: begin
                        if (r_cnt == 2'd0) begin
                            n_cleft = 32'd0;
                        end
                        n_cleft[{r_cnt, 3'b000} +: 8] = i_in_byte;
                        n_cnt = r_cnt + 2'd1;
                        if (r_cnt == 2'd3) begin
                            n_phase = PH_HDR_ESC;
                        end
                    end
                    PH_HDR_ESC: begin
                        n_esc   = i_in_byte;
                        n_cleft = cl_hdr;
                        n_prod  = 32'd0;
                        n_phase = (cl_hdr == 32'd0) ? PH_HDR_ORIG : PH_IDLE;
                        n_cnt   = 2'd0;
                    end
                    PH_IDLE: begin
                        n_cleft = cl_dec;
                        if (i_in_byte != r_esc) begin
                            item.has_result = 1'b1;
                            item.wr_en      = 1'b1;
                            n_prod          = prod_inc;
                            n_phase = (cl_dec == 32'd0) ? PH_HDR_ORIG : PH_IDLE;
                            n_cnt   = 2'd0;
                        end else begin
                            n_phase = PH_ESC;
                        end
                    end
                    PH_ESC: begin
                        n_cleft = cl_dec;
                        if (i_in_byte == r_esc) begin
                            item.has_result = 1'b1;
                            item.wr_en      = 1'b1;
                            n_prod          = prod_inc;
                            n_phase = (cl_dec == 32'd0) ? PH_HDR_ORIG : PH_IDLE;
                            n_cnt   = 2'd0;
                        end else begin
                            n_dsize = code[1:0];
                            n_len   = {9'd0, code[7:3]};
                            if (code[1:0] == esc_lz_pkg::DIST_SIZE_MASK) begin
                                item.has_result = 1'b1;
                                item.err        = esc_lz_pkg::ERR_DIST_SIZE;
                                item.lit_byte   = 8'd0;
                                item.last       = 1'b0;
                                n_phase = (cl_dec == 32'd0) ? PH_HDR_ORIG : PH_IDLE;
                                n_cnt   = 2'd0;
                            end else if (code[esc_lz_pkg::LEN_EXT_BIT]) begin
                                n_phase = PH_LEN_EXT;
                            end else begin
                                n_len   = {9'd0, code[7:3]} + esc_lz_pkg::MIN_MATCH;
                                n_phase = PH_DIST;
                                n_cnt   = 2'd0;
                                n_dist  = 25'd0;
                            end
                        end
                    end
                    PH_LEN_EXT: begin
                        n_cleft = cl_dec;
                        n_len   = {1'b0, i_in_byte, r_len[4:0]} + esc_lz_pkg::MIN_MATCH;
                        n_phase = PH_DIST;
                        n_cnt   = 2'd0;
                        n_dist  = 25'd0;
                    end
                    PH_DIST: begin
                        n_cleft = cl_dec;
                        if (r_cnt >= r_dsize) begin
                            n_dist = dist_fin;
                            n_cnt  = 2'd0;
                            if (({7'd0, dist_fin} > r_prod) ||
                                (dist_fin > 25'(esc_lz_pkg::HIST_DEPTH))) begin
                                item.has_result = 1'b1;
                                item.err        = esc_lz_pkg::ERR_DIST_FAR;
                                item.lit_byte   = 8'd0;
                                item.last       = 1'b0;
                                n_phase = (cl_dec == 32'd0) ? PH_HDR_ORIG : PH_IDLE;
                            end else begin
                                n_phase = PH_COPY;
                            end
                        end else begin
                            n_dist = dist_acc;
                            n_cnt  = r_cnt + 2'd1;
                        end
                    end
                    default: begin
                        n_phase = PH_HDR_ORIG;
                        n_cnt   = 2'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR_ORIG;
            r_cnt   <= 2'd0;
            r_orig  <= 32'd0;
            r_cleft <= 32'd0;
            r_esc   <= 8'd0;
            r_dsize <= 2'd0;
            r_len   <= 14'd0;
            r_dist  <= 25'd0;
            r_prod  <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_orig  <= n_orig;
            r_cleft <= n_cleft;
            r_esc   <= n_esc;
            r_dsize <= n_dsize;
            r_len   <= n_len;
            r_dist  <= n_dist;
            r_prod  <= n_prod;
        end
    end

    assign o_item = item;

endmodule

// ----- hw/rtl/escape_lz_decompressor_core.sv -----
`timescale 1ns / 1ps

// Escape-code LZ77 decompressor. Each transfer on the input carries either one
// compressed byte (op 0) or a request for the next byte of a pending match copy
// (op 1); each transfer gives at most one output byte, with last_byte marking
// the byte at which the declared original size is reached and error flagging
// a bad distance size, a distance too far, or an item out of phase. The block
// takes one transfer every clock cycle, copies included, when the output is not
// back-pressured; a result passes through the resolve stage and then the output
// register. The parser updates all control state in the cycle of the transfer
// and issues the history read at once; the byte is resolved from the registered
// history read in the resolve stage and written back to history as it leaves
// that stage, with a bypass for a copy that reads the entry written on the edge
// that issued the read (distance one). History is never cleared: only entries
// of the current stream are read, so there is no clearing pass after reset.
module escape_lz_decompressor_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte,
    output logic [1:0] o_error
);

    // input transfer and parser output
    logic              in_acc;
    esc_lz_pkg::t_item item;

    // resolve stage, one item deep
    logic              r_b_valid;
    esc_lz_pkg::t_item r_b;
    logic              r_fwd_hit;
    logic [7:0]        r_fwd_byte;
    logic [7:0]        b_byte;
    logic [7:0]        rdata;
    logic              b_move;

    // output register
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    esc_lz_pkg::t_err  r_out_err;
    logic              out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign b_move     = r_b_valid && out_free;
    // a new item may enter whenever the resolve stage is empty or empties this cycle
    assign o_in_ready = !r_b_valid || out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    esc_lz_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (in_acc),
        .i_op      (i_op),
        .i_in_byte (i_in_byte),
        .o_item    (item)
    );

    // history window: written as each byte leaves the resolve stage, read
    // when a copy transfer is taken
    esc_lz_ram #(
        .ADDR_W (esc_lz_pkg::HIST_AW),
        .DATA_W (8)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (b_move && r_b.wr_en),
        .i_waddr (r_b.wr_addr),
        .i_wdata (b_byte),
        .i_re    (in_acc && item.is_copy),
        .i_raddr (item.rd_addr),
        .o_rdata (rdata)
    );

    // copy byte comes from memory unless the entry was written on the very
    // edge that issued the read
    assign b_byte = !r_b.is_copy ? r_b.lit_byte :
                    (r_fwd_hit ? r_fwd_byte : rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (in_acc) begin
                // items without a result (header bytes, token bytes) stop here
                r_b_valid <= item.has_result;
                r_fwd_hit <= b_move && r_b.wr_en && (r_b.wr_addr == item.rd_addr);
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
        end
        if (in_acc) begin
            r_b        <= item;
            r_fwd_byte <= b_byte;
        end
    end

    // output register, loaded from the resolve stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_b_valid;
        end
        if (b_move) begin
            r_out_byte <= b_byte;
            r_out_last <= r_b.last;
            r_out_err  <= r_b.err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;
    assign o_error     = r_out_err;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

// self-checking bench for the escape-code lz decompressor
// stimulus is planned against a lookahead copy of the decoder so that most
// transfers form well-shaped streams (header, literals, doubled escapes,
// matches with their copy requests) with some noise and broken tokens mixed in
// a second copy of the same decoder scores the transfers the block accepts
module tb;

    import esc_lz_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned MAX_LONG_EXT = 2;    // cap on very long matches
    localparam int unsigned MIRROR_GEN   = 0;    // decoder copy used for planning
    localparam int unsigned MIRROR_CHK   = 1;    // decoder copy used for scoring

    // decoder phases
    typedef enum logic [3:0] {
        ST_ORIG_SIZE = 4'd0,
        ST_COMP_SIZE = 4'd1,
        ST_ESC_BYTE  = 4'd2,
        ST_BODY      = 4'd3,
        ST_AFTER_ESC = 4'd4,
        ST_LEN_EXT   = 4'd5,
        ST_DISTANCE  = 4'd6,
        ST_COPY      = 4'd7
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  byte_idx;       // position within a multi-byte field
        logic [31:0] declared_size;
        logic [31:0] body_left;      // compressed bytes still to come
        logic [7:0]  escape;
        logic [7:0]  code;           // token after escape adjustment
        logic [13:0] copy_len;
        logic [24:0] copy_dist;
        logic [31:0] n_out;          // bytes produced in this stream
    } t_dec_state;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_err       err;
    } t_result;

    // one queued input transfer, with the idling mode it is sent under
    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic [1:0] mode;
        logic       drain;           // hold off until every expected result is in
    } t_stim;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    logic       i_op        = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_last_byte;
    logic [1:0] o_error;
    logic [1:0] cur_mode    = 2'd0;

    t_dec_state  dec [2];
    logic [7:0]  hist [0:2*HIST_DEPTH-1];

    t_stim       pending_items[$];
    t_result     expected_bytes[$];

    // stream plan of the generator
    logic [31:0] plan_orig;
    logic [31:0] plan_comp;
    logic [7:0]  plan_esc;
    logic [31:0] plan_dist;
    int unsigned n_long_ext = 0;

    int unsigned n_streams  = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results  = 0;
    int unsigned n_last     = 0;
    int unsigned n_fail     = 0;
    int unsigned err_seen [4];

    escape_lz_decompressor_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte),
        .o_error     (o_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // idle percentage per mode: sender light / receiver heavy, then swapped,
    // then no idling at all
    function automatic int unsigned idle_pct(logic [1:0] mode, bit rx);
        case (mode)
            2'd0:    return rx ? 83 : 26;
            2'd1:    return rx ? 26 : 83;
            default: return 0;
        endcase
    endfunction

    // where the decoder goes once a token is finished
    function automatic t_phase token_done_phase(logic [31:0] left);
        return (left == 0) ? ST_ORIG_SIZE : ST_BODY;
    endfunction

    // one transfer through decoder copy 'who'; returns 1 when it gives a result
    function automatic bit decode_item(input int unsigned who, input logic op,
                                       input logic [7:0] b, output t_result res);
        t_dec_state  s;
        logic [7:0]  code;
        logic [7:0]  put_val;
        int unsigned rd;
        bit          put;
        bit          got;
        s       = dec[who];
        res     = '0;
        put     = 1'b0;
        got     = 1'b0;
        put_val = 8'h00;
        if (op) begin
            if (s.phase != ST_COPY) begin
                res.err = ERR_UNEXPECTED;
                got     = 1'b1;
            end else begin
                // overlapping copies simply read bytes produced earlier in the match
                rd = (s.n_out % HIST_DEPTH + HIST_DEPTH - 32'(s.copy_dist)) % HIST_DEPTH;
                put_val    = hist[who*HIST_DEPTH + rd];
                put        = 1'b1;
                s.copy_len = s.copy_len - 14'd1;
                if (s.copy_len == 0) begin
                    s.phase    = token_done_phase(s.body_left);
                    s.byte_idx = '0;
                end
            end
        end else if (s.phase == ST_COPY) begin
            // a byte while a copy is pending leaves everything as it was
            res.err = ERR_UNEXPECTED;
            got     = 1'b1;
        end else begin
            if (s.phase != ST_ORIG_SIZE && s.phase != ST_COMP_SIZE &&
                s.phase != ST_ESC_BYTE && s.body_left != 0)
                s.body_left = s.body_left - 1;
            case (s.phase)
                ST_ORIG_SIZE: begin
                    if (s.byte_idx == 0)
                        s.declared_size = '0;
                    s.declared_size = s.declared_size | (32'(b) << (8 * s.byte_idx));
                    s.byte_idx = s.byte_idx + 3'd1;
                    if (s.byte_idx >= 4) begin
                        s.byte_idx = '0;
                        s.phase    = ST_COMP_SIZE;
                    end
                end
                ST_COMP_SIZE: begin
                    if (s.byte_idx == 0)
                        s.body_left = '0;
                    s.body_left = s.body_left | (32'(b) << (8 * s.byte_idx));
                    s.byte_idx  = s.byte_idx + 3'd1;
                    if (s.byte_idx >= 4) begin
                        s.byte_idx = '0;
                        s.phase    = ST_ESC_BYTE;
                    end
                end
                ST_ESC_BYTE: begin
                    // compressed size counts the header, short sizes mean no body
                    s.escape    = b;
                    s.body_left = (s.body_left >= HEADER_BYTES) ?
                                  s.body_left - HEADER_BYTES : '0;
                    s.n_out     = '0;
                    s.phase     = token_done_phase(s.body_left);
                    s.byte_idx  = '0;
                end
                ST_BODY: begin
                    if (b != s.escape) begin
                        put_val    = b;
                        put        = 1'b1;
                        s.phase    = token_done_phase(s.body_left);
                        s.byte_idx = '0;
                    end else begin
                        s.phase = ST_AFTER_ESC;
                    end
                end
                ST_AFTER_ESC: begin
                    if (b == s.escape) begin
                        put_val    = b;
                        put        = 1'b1;
                        s.phase    = token_done_phase(s.body_left);
                        s.byte_idx = '0;
                    end else begin
                        code       = (b > s.escape) ? b - 8'd1 : b;
                        s.code     = code;
                        s.copy_len = 14'(code >> 3);
                        if (code[1:0] == DIST_SIZE_MASK) begin
                            s.phase    = token_done_phase(s.body_left);
                            s.byte_idx = '0;
                            res.err    = ERR_DIST_SIZE;
                            got        = 1'b1;
                        end else if (code[LEN_EXT_BIT]) begin
                            s.phase = ST_LEN_EXT;
                        end else begin
                            s.copy_len  = s.copy_len + MIN_MATCH;
                            s.phase     = ST_DISTANCE;
                            s.byte_idx  = '0;
                            s.copy_dist = '0;
                        end
                    end
                end
                ST_LEN_EXT: begin
                    s.copy_len  = (s.copy_len | (14'(b) << 5)) + MIN_MATCH;
                    s.phase     = ST_DISTANCE;
                    s.byte_idx  = '0;
                    s.copy_dist = '0;
                end
                ST_DISTANCE: begin
                    s.copy_dist = s.copy_dist | (25'(b) << (8 * s.byte_idx));
                    s.byte_idx  = s.byte_idx + 3'd1;
                    if (s.byte_idx >= {1'b0, s.code[1:0]} + 3'd1) begin
                        s.byte_idx  = '0;
                        s.copy_dist = s.copy_dist + 25'd1;
                        if (32'(s.copy_dist) > s.n_out ||
                            32'(s.copy_dist) > HIST_DEPTH) begin
                            s.phase = token_done_phase(s.body_left);
                            res.err = ERR_DIST_FAR;
                            got     = 1'b1;
                        end else begin
                            s.phase = ST_COPY;
                        end
                    end
                end
                default: begin
                    s = '0;
                end
            endcase
        end
        if (put) begin
            hist[who*HIST_DEPTH + s.n_out % HIST_DEPTH] = put_val;
            s.n_out  = s.n_out + 1;
            res.data = put_val;
            res.last = (s.n_out == s.declared_size);
            got      = 1'b1;
        end
        dec[who] = s;
        return got;
    endfunction

    task automatic queue_item(input logic op, input logic [7:0] b,
                              input logic [1:0] mode, input bit drain);
        t_result unused;
        t_stim   item;
        bit      got;
        got        = decode_item(MIRROR_GEN, op, b, unused);
        item.op    = op;
        item.data  = b;
        item.mode  = mode;
        item.drain = drain;
        pending_items.push_back(item);
    endtask

    // pick the next transfer from where the lookahead decoder stands
    task automatic next_random_item(output logic op, output logic [7:0] b);
        t_dec_state  m;
        int unsigned r;
        int unsigned lim;
        int unsigned code;
        int unsigned body_len;
        m  = dec[MIRROR_GEN];
        op = 1'b0;
        b  = 8'($urandom_range(0, 255));
        r  = $urandom_range(0, 99);
        if (m.phase != ST_ORIG_SIZE && m.phase != ST_COMP_SIZE &&
            m.phase != ST_ESC_BYTE && $urandom_range(0, 99) < 3) begin
            // noise: any op, any byte
            op = 1'($urandom_range(0, 1));
        end else begin
            case (m.phase)
                ST_ORIG_SIZE: begin
                    if (m.byte_idx == 0) begin
                        body_len = $urandom_range(8, 100);
                        case ($urandom_range(0, 19))
                            0:       plan_comp = $urandom_range(0, 9);
                            1:       plan_comp = 32'd10;
                            default: plan_comp = HEADER_BYTES + body_len;
                        endcase
                        case ($urandom_range(0, 9))
                            0:       plan_orig = 32'hFFFF_FFFF;
                            1:       plan_orig = 32'd0;
                            2:       plan_orig = $urandom;
                            default: plan_orig = $urandom_range(1, body_len);
                        endcase
                        case ($urandom_range(0, 4))
                            0:       plan_esc = 8'h00;
                            1:       plan_esc = 8'hFF;
                            default: plan_esc = 8'($urandom_range(0, 255));
                        endcase
                        n_streams++;
                    end
                    b = 8'(plan_orig >> (8 * m.byte_idx));
                end
                ST_COMP_SIZE: b = 8'(plan_comp >> (8 * m.byte_idx));
                ST_ESC_BYTE:  b = plan_esc;
                ST_BODY: begin
                    if (r < 4)
                        op = 1'b1;           // copy request with nothing pending
                    else if (r < 30)
                        b = m.escape;
                end
                ST_AFTER_ESC: begin
                    if (r < 15) begin
                        b = m.escape;        // doubled escape
                    end else begin
                        if (r < 23) begin
                            // distance size code 3
                            code = ($urandom_range(0, 30) << 3) |
                                   ($urandom_range(0, 1) << 2) | 3;
                        end else begin
                            code = ($urandom_range(0, 31) << 3) |
                                   (($urandom_range(0, 99) < 20) ? 4 : 0);
                            lim  = $urandom_range(0, 99);
                            code = code | ((lim < 60) ? 0 : (lim < 85) ? 1 : 2);
                        end
                        b = (code >= m.escape) ? 8'(code + 1) : 8'(code);
                    end
                end
                ST_LEN_EXT: begin
                    if (r < 85) begin
                        b = 8'($urandom_range(0, 1));
                    end else if (r < 97 || n_long_ext >= MAX_LONG_EXT) begin
                        b = 8'($urandom_range(2, 7));
                    end else begin
                        n_long_ext++;
                    end
                end
                ST_DISTANCE: begin
                    if (m.byte_idx == 0) begin
                        if (m.n_out == 0 || r < 10) begin
                            plan_dist = $urandom;    // usually too far
                        end else begin
                            lim = m.n_out;
                            if (m.code[1:0] == 2'd0 && lim > 256)
                                lim = 256;
                            if ($urandom_range(0, 1) == 0 && lim > 8)
                                lim = 8;
                            plan_dist = $urandom_range(1, lim) - 1;
                        end
                    end
                    b = 8'(plan_dist >> (8 * m.byte_idx));
                end
                ST_COPY: begin
                    op = (r >= 4);
                end
                default: ;
            endcase
        end
    endtask

    // driver: a new transfer is offered only when the slot is free
    always @(posedge i_clk) begin : drive_proc
        t_result res;
        t_stim   nxt;
        bit      free;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            free = !i_in_valid;
            if (i_in_valid && o_in_ready) begin
                n_accepted++;
                if (decode_item(MIRROR_CHK, i_op, i_in_byte, res))
                    expected_bytes.push_back(res);
                free = 1'b1;
            end
            if (free) begin
                if (pending_items.size() == 0 ||
                    (pending_items[0].drain && expected_bytes.size() != 0) ||
                    $urandom_range(0, 99) < idle_pct(pending_items[0].mode, 1'b0)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    nxt = pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    i_op       <= nxt.op;
                    i_in_byte  <= nxt.data;
                    cur_mode   <= nxt.mode;
                end
            end
        end
    end

    // monitor: every result transfer is matched against the oldest expectation
    always @(posedge i_clk) begin : watch_proc
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (expected_bytes.size() == 0) begin
                    n_fail++;
                    $error("result with none expected: out_byte %0h error %0d",
                           o_out_byte, o_error);
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want.data) begin
                        n_fail++;
                        $error("out_byte: expected %0h, got %0h", want.data, o_out_byte);
                    end
                    if (o_last_byte !== want.last) begin
                        n_fail++;
                        $error("last_byte: expected %0b, got %0b", want.last, o_last_byte);
                    end
                    if (o_error !== want.err) begin
                        n_fail++;
                        $error("error: expected %0d, got %0d", want.err, o_error);
                    end
                    if (want.last)
                        n_last++;
                    err_seen[want.err]++;
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= idle_pct(cur_mode, 1'b1));
        end
    end

    initial begin : main_proc
        logic        op;
        logic [7:0]  b;
        logic [1:0]  mode;
        int unsigned k;
        for (k = 0; k < 2; k++)
            dec[k] = '0;
        for (k = 0; k < 4; k++)
            err_seen[k] = 0;

        // directed: copy request straight after reset
        queue_item(1'b1, 8'h00, 2'd0, 1'b0);
        // header: declared size 3, compressed size 9 + 13, escape 0x80
        for (k = 0; k < 4; k++)
            queue_item(1'b0, 8'(32'd3 >> (8 * k)), 2'd0, 1'b0);
        for (k = 0; k < 4; k++)
            queue_item(1'b0, 8'(32'd22 >> (8 * k)), 2'd0, 1'b0);
        queue_item(1'b0, 8'h80, 2'd0, 1'b0);
        n_streams++;
        // extreme literals, then a doubled escape landing on the declared size
        queue_item(1'b0, 8'h00, 2'd0, 1'b0);
        queue_item(1'b0, 8'hFF, 2'd0, 1'b0);
        queue_item(1'b0, 8'h80, 2'd0, 1'b0);
        queue_item(1'b0, 8'h80, 2'd0, 1'b0);
        // token with distance size code 3
        queue_item(1'b0, 8'h80, 2'd0, 1'b0);
        queue_item(1'b0, 8'h03, 2'd0, 1'b0);
        // one-byte distance of 256, past everything produced
        queue_item(1'b0, 8'h80, 2'd0, 1'b0);
        queue_item(1'b0, 8'h00, 2'd0, 1'b0);
        queue_item(1'b0, 8'hFF, 2'd0, 1'b0);
        // length extension, distance 1, stray byte mid-copy, then the copy
        queue_item(1'b0, 8'h80, 2'd0, 1'b0);
        queue_item(1'b0, 8'h04, 2'd0, 1'b0);
        queue_item(1'b0, 8'h00, 2'd0, 1'b0);
        queue_item(1'b0, 8'h00, 2'd0, 1'b0);
        queue_item(1'b0, 8'hA5, 2'd0, 1'b0);
        for (k = 0; k < 4; k++)
            queue_item(1'b1, 8'h00, 2'd0, 1'b0);

        // random streams across the three idling modes
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            mode = (k < RANDOM_ITEMS / 3) ? 2'd0 : (k < 2 * RANDOM_ITEMS / 3) ? 2'd1 : 2'd2;
            next_random_item(op, b);
            queue_item(op, b, mode,
                       k == RANDOM_ITEMS / 3 || k == 2 * RANDOM_ITEMS / 3 ||
                       $urandom_range(0, 199) == 0);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d input transfers over %0d streams, %0d results checked (%0d at size)",
                 n_accepted, n_streams, n_results, n_last);
        $display("error results: bad distance size %0d, too far %0d, out of phase %0d",
                 err_seen[ERR_DIST_SIZE], err_seen[ERR_DIST_FAR], err_seen[ERR_UNEXPECTED]);
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
